// ----- hdl/dmac_pkg.sv -----
package dmac_pkg;

  localparam int CHANNELS_DEF       = 4;
  localparam int MAX_CHUNK_LOG2_DEF = 6;

  // action codes
  localparam logic [1:0] ACT_WRITE = 2'd0;
  localparam logic [1:0] ACT_READ  = 2'd1;
  localparam logic [1:0] ACT_TICK  = 2'd2;

  // register indexes
  localparam logic [3:0] REG_CTRL     = 4'd0;
  localparam logic [3:0] REG_NCFG     = 4'd1;
  localparam logic [3:0] REG_NBYTES   = 4'd2;
  localparam logic [3:0] REG_NDST     = 4'd3;
  localparam logic [3:0] REG_NSRC     = 4'd4;
  localparam logic [3:0] REG_XCFG     = 4'd5;
  localparam logic [3:0] REG_XBYTES   = 4'd6;
  localparam logic [3:0] REG_XDST     = 4'd7;
  localparam logic [3:0] REG_XSRC     = 4'd8;

  // status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_BUSY = 2'd1;
  localparam logic [1:0] ST_IDLE = 2'd2;

  // control bits
  localparam int B_CLAIM   = 0;
  localparam int B_RUN     = 1;
  localparam int B_REPEAT  = 2;
  localparam int B_DONE_IE = 14;
  localparam int B_ERR_IE  = 15;
  localparam int B_DONE    = 30;
  localparam int B_ERR     = 31;
  localparam int WSIZE_POS = 24;
  localparam int RSIZE_POS = 28;
  localparam logic [31:0] CLAIM_CFG = 32'h6600_0000;

  typedef struct packed {
    logic [1:0]  action;
    logic [1:0]  channel;
    logic [3:0]  register_index;
    logic [63:0] write_data;
  } in_word_t;

  typedef struct packed {
    logic [63:0] read_data;
    logic        copy_valid;
    logic [63:0] copy_source;
    logic [63:0] copy_destination;
    logic [6:0]  copy_length;
    logic        copy_last;
    logic [3:0]  done_irq_lines;
    logic [3:0]  error_irq_lines;
    logic [1:0]  status;
  } out_word_t;

  // per-channel state record held in the channel memory
  typedef struct packed {
    logic [31:0] ctrl;
    logic [31:0] ncfg;
    logic [63:0] nlen;
    logic [63:0] ndst;
    logic [63:0] nsrc;
    logic [31:0] xcfg;
    logic [63:0] xlen;
    logic [63:0] xdst;
    logic [63:0] xsrc;
  } chan_rec_t;

  localparam int REC_W = $bits(chan_rec_t);

endpackage

// ----- hdl/dmac_ram.sv -----
module dmac_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hdl/dmac_exec.sv -----
module dmac_exec import dmac_pkg::*; #(
  parameter int MAX_CHUNK_LOG2 = MAX_CHUNK_LOG2_DEF
) (
  input  in_word_t  req,
  input  logic      ch_ok,
  input  logic      active,
  input  chan_rec_t rec,
  output chan_rec_t rec_next,
  output logic      wr_en,
  output logic      active_next,
  output logic      set_active,
  output logic      irq_upd,
  output logic [1:0] irq_bits,
  output out_word_t res
);

  logic [31:0] v;
  logic        claimed, running, refuse;
  logic [3:0]  sz;
  logic [2:0]  szc;
  logic [6:0]  chunk;
  logic [63:0] len;
  logic [63:0] rem;

  always_comb begin
    rec_next    = rec;
    wr_en       = 1'b0;
    active_next = active;
    set_active  = 1'b0;
    irq_upd     = 1'b0;
    res         = '0;
    claimed     = rec.ctrl[B_CLAIM];
    running     = rec.ctrl[B_RUN];
    v           = req.write_data[31:0];
    refuse      = 1'b0;
    sz          = rec.xcfg[WSIZE_POS +: 4];
    szc         = (sz > 4'(MAX_CHUNK_LOG2)) ? 3'(MAX_CHUNK_LOG2) : sz[2:0];
    chunk       = 7'd1 << szc;
    len         = (rec.xlen < {57'd0, chunk}) ? rec.xlen : {57'd0, chunk};
    rem         = rec.xlen - len;
    unique case (req.action)
      ACT_WRITE: begin
        if (active) begin
          res.status = ST_BUSY;
        end else if (ch_ok) begin
          wr_en = 1'b1;
          unique case (req.register_index)
            REG_CTRL: begin
              if (!claimed && v[B_CLAIM]) begin
                rec_next.ncfg = CLAIM_CFG;
                rec_next.nlen = '0;
                rec_next.ndst = '0;
                rec_next.nsrc = '0;
              end
              if (running && !v[B_CLAIM]) v[B_CLAIM] = 1'b1;
              refuse = !claimed || (!running && !v[B_CLAIM]);
              if (refuse) begin
                v[B_RUN] = 1'b0;
              end else if (v[B_RUN]) begin
                // start: zero length, size check, or load exec copy
                if (rec_next.nlen == '0) begin
                  v[B_RUN]  = 1'b0;
                  v[B_DONE] = 1'b1;
                end else if (rec_next.ncfg[WSIZE_POS +: 4] != rec_next.ncfg[RSIZE_POS +: 4])
                begin
                  v[B_ERR] = 1'b1;
                end else begin
                  v[B_DONE]     = 1'b0;
                  v[B_ERR]      = 1'b0;
                  rec_next.xcfg = rec_next.ncfg;
                  rec_next.xlen = rec_next.nlen;
                  rec_next.xdst = rec_next.ndst;
                  rec_next.xsrc = rec_next.nsrc;
                  active_next   = 1'b1;
                  set_active    = 1'b1;
                end
              end
              rec_next.ctrl = v;
              irq_upd       = !refuse;
            end
            REG_NCFG:   rec_next.ncfg = v;
            REG_NBYTES: rec_next.nlen = req.write_data;
            REG_NDST:   rec_next.ndst = req.write_data;
            REG_NSRC:   rec_next.nsrc = req.write_data;
            default:    wr_en = 1'b0;
          endcase
        end
      end
      ACT_READ: begin
        if (ch_ok) begin
          unique case (req.register_index)
            REG_CTRL:   res.read_data = {32'd0, rec.ctrl};
            REG_NCFG:   res.read_data = {32'd0, rec.ncfg};
            REG_NBYTES: res.read_data = rec.nlen;
            REG_NDST:   res.read_data = rec.ndst;
            REG_NSRC:   res.read_data = rec.nsrc;
            REG_XCFG:   res.read_data = {32'd0, rec.xcfg};
            REG_XBYTES: res.read_data = rec.xlen;
            REG_XDST:   res.read_data = rec.xdst;
            REG_XSRC:   res.read_data = rec.xsrc;
            default:    res.read_data = '0;
          endcase
        end
      end
      ACT_TICK: begin
        if (!active) begin
          res.status = ST_IDLE;
        end else begin
          // issue one chunk, advance the exec registers
          wr_en                = 1'b1;
          res.copy_valid       = 1'b1;
          res.copy_source      = rec.xsrc;
          res.copy_destination = rec.xdst;
          res.copy_length      = len[6:0];
          rec_next.xsrc        = rec.xsrc + len;
          rec_next.xdst        = rec.xdst + len;
          rec_next.xlen        = rem;
          if (rem == '0) begin
            res.copy_last     = 1'b1;
            active_next       = 1'b0;
            rec_next.ctrl[B_RUN]  = 1'b0;
            rec_next.ctrl[B_DONE] = 1'b1;
            if (rec.ncfg[B_REPEAT]) begin
              rec_next.xlen = rec.nlen;
              rec_next.xdst = rec.ndst;
              rec_next.xsrc = rec.nsrc;
            end
            irq_upd = 1'b1;
          end
        end
      end
      default: ;
    endcase
    irq_bits = {rec_next.ctrl[B_ERR_IE] & rec_next.ctrl[B_ERR],
                rec_next.ctrl[B_DONE_IE] & rec_next.ctrl[B_DONE]};
  end

endmodule

// ----- hdl/dma_channel_controller.sv -----
// Channel   | valid     | stall     | payload
// ----------+-----------+-----------+----------------
// request   | req_valid | req_stall | req (in_word_t)
// result    | res_valid | res_stall | res (out_word_t)
//
// One word per cycle while req_stall is low: the channel record is read from
// memory in the cycle a word is taken and modified and written back in the
// next; a back-to-back access to the same record takes the forwarded write
// instead of the RAM. Results sit in a three-entry buffer; outside the
// clearing pass, req_stall rises only when the words in it and the one in
// flight would fill it. Synchronous reset runs a clearing pass that zeroes
// each of the CHANNELS records, during which no word is accepted.
module dma_channel_controller import dmac_pkg::*; #(
  parameter int CHANNELS       = CHANNELS_DEF,
  parameter int MAX_CHUNK_LOG2 = MAX_CHUNK_LOG2_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_stall,
  input  in_word_t  req,
  output logic      res_valid,
  input  logic      res_stall,
  output out_word_t res
);

  localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int RD = (CHANNELS > 1) ? CHANNELS : 2;

  logic          clearing;
  logic [AW:0]   clr_cnt;
  logic          s1_valid;
  in_word_t      s1_req;
  logic          s1_ok;
  logic          active;
  logic [AW-1:0] act_ch;
  logic [7:0]    irq;
  logic          fwd_valid;
  logic [AW-1:0] fwd_addr;
  chan_rec_t     fwd_rec;
  logic [REC_W-1:0] ram_q;
  chan_rec_t     rec_cur, rec_next;
  logic          wr_en, active_next, set_active, irq_upd;
  logic [1:0]    irq_bits;
  out_word_t     ex_res;
  logic [7:0]    irq_next;
  logic [1:0]    cnt;
  out_word_t     rbuf [3];
  logic [1:0]    rd_ptr, wr_ptr;
  logic          take;
  logic [AW-1:0] rd_addr, s1_addr;
  logic          we;
  logic [AW-1:0] waddr;
  chan_rec_t     wdata;

  assign req_stall = clearing || (cnt == 2'd3) || (cnt == 2'd2 && s1_valid);
  assign take      = req_valid && !req_stall;

  // channel of the word: ticks use the active channel, or the one that the
  // word ahead is starting
  assign rd_addr = (req.action == ACT_TICK) ?
                   ((s1_valid && set_active) ? s1_addr : act_ch) :
                   req.channel[AW-1:0];
  always_ff @(posedge clk) begin
    if (take) begin
      s1_req  <= req;
      s1_addr <= rd_addr;
      s1_ok   <= (req.action == ACT_TICK) || ({2'b0, req.channel} < 4'(CHANNELS));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= take;
    end
  end

  // clearing pass
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_cnt  <= '0;
    end else if (clearing) begin
      clr_cnt <= clr_cnt + 1'b1;
      if (clr_cnt == (AW+1)'(CHANNELS - 1)) clearing <= 1'b0;
    end
  end

  dmac_ram #(.WIDTH(REC_W), .DEPTH(RD)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (rd_addr),
    .rdata (ram_q)
  );

  // forward the last write-back when it hits the same record
  assign rec_cur = (fwd_valid && fwd_addr == s1_addr) ? fwd_rec : chan_rec_t'(ram_q);

  dmac_exec #(.MAX_CHUNK_LOG2(MAX_CHUNK_LOG2)) u_exec (
    .req         (s1_req),
    .ch_ok       (s1_ok),
    .active      (active),
    .rec         (rec_cur),
    .rec_next    (rec_next),
    .wr_en       (wr_en),
    .active_next (active_next),
    .set_active  (set_active),
    .irq_upd     (irq_upd),
    .irq_bits    (irq_bits),
    .res         (ex_res)
  );

  assign we    = clearing || (s1_valid && wr_en);
  assign waddr = clearing ? clr_cnt[AW-1:0] : s1_addr;
  assign wdata = clearing ? chan_rec_t'('0) : rec_next;

  always_comb begin
    irq_next = irq;
    if (irq_upd) irq_next[{s1_addr, 1'b0} +: 2] = irq_bits;
  end

  // global state and forwarding register
  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      act_ch    <= '0;
      irq       <= '0;
      fwd_valid <= 1'b0;
    end else begin
      fwd_valid <= s1_valid && wr_en;
      if (s1_valid) begin
        active <= active_next;
        irq    <= irq_next;
        if (set_active) act_ch <= s1_addr;
      end
    end
  end
  always_ff @(posedge clk) begin
    fwd_addr <= s1_addr;
    fwd_rec  <= rec_next;
  end

  // result buffer
  out_word_t s1_res;
  always_comb begin
    s1_res = ex_res;
    for (int k = 0; k < 4; k++) begin
      s1_res.done_irq_lines[k]  = irq_next[2*k];
      s1_res.error_irq_lines[k] = irq_next[2*k+1];
    end
  end

  logic pop;
  assign pop = res_valid && !res_stall;
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt    <= '0;
      rd_ptr <= '0;
      wr_ptr <= '0;
    end else begin
      cnt <= cnt + {1'b0, s1_valid} - {1'b0, pop};
      if (s1_valid) wr_ptr <= (wr_ptr == 2'd2) ? 2'd0 : wr_ptr + 2'd1;
      if (pop) rd_ptr <= (rd_ptr == 2'd2) ? 2'd0 : rd_ptr + 2'd1;
    end
  end
  always_ff @(posedge clk) begin
    if (s1_valid) begin
      rbuf[wr_ptr] <= s1_res;
    end
  end
  assign res_valid = (cnt != 2'd0);
  assign res       = rbuf[rd_ptr];

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(cnt == 2'd3 && s1_valid && !pop)) else $error("result buffer overflow");
  a_clear_blocks: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !take) else $error("word taken during clear");
  a_copy_active: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s1_res.copy_valid) |-> active) else $error("copy without transfer");
`endif

endmodule
